FILE: sv/scpf_pkg.sv
// ----------------------------------------------------------------------------
// scpf_pkg
// Shared types and constants for the sensor command packet framer.
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned WIRE_EXTRA  = 2;

  localparam logic [15:0] WAKE_CODE_RST = 16'hEF01;
  localparam logic [31:0] DEV_ADDR_RST  = 32'hFFFF_FFFF;

  // config register index
  localparam logic CFG_WAKE_CODE = 1'b0;
  localparam logic CFG_DEV_ADDR  = 1'b1;

  // byte position inside one request's burst
  typedef enum logic [3:0] {
    POS_START_HI = 4'd0,
    POS_START_LO = 4'd1,
    POS_ADDR_3   = 4'd2,
    POS_ADDR_2   = 4'd3,
    POS_ADDR_1   = 4'd4,
    POS_ADDR_0   = 4'd5,
    POS_TYPE     = 4'd6,
    POS_LEN_HI   = 4'd7,
    POS_LEN_LO   = 4'd8,
    POS_DATA     = 4'd9,
    POS_SUM_HI   = 4'd10,
    POS_SUM_LO   = 4'd11
  } pos_e;

  // everything the sequencer needs to emit one request's bytes
  typedef struct packed {
    logic        hdr;
    logic        fin;
    logic [15:0] wake_code;
    logic [31:0] dev_addr;
    logic [7:0]  ptype;
    logic [15:0] wire_len;
    logic [7:0]  data;
    logic [15:0] sum;
  } job_t;

endpackage

FILE: sv/scpf_front.sv
// ----------------------------------------------------------------------------
// scpf_front
// Config registers, packet state and checksum; builds the burst descriptor.
// ----------------------------------------------------------------------------
module scpf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                accept_i,
  input  logic [7:0]          packet_type_i,
  input  logic [6:0]          payload_length_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  input  logic                final_byte_i,
  output scpf_pkg::job_t      job_o,
  output logic                job_en_o
);
  import scpf_pkg::*;

  logic [15:0] wake_code_q;
  logic [31:0] dev_addr_q;
  logic [15:0] sum_q, sum_d;
  logic        in_pkt_q, in_pkt_d;
  logic [15:0] plen_c;
  logic [15:0] wire_len;
  logic [15:0] base_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_code_q <= WAKE_CODE_RST;
      dev_addr_q  <= DEV_ADDR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WAKE_CODE: wake_code_q <= cfg_wdata_i[15:0];
        CFG_DEV_ADDR:  dev_addr_q  <= cfg_wdata_i;
        default:       wake_code_q <= wake_code_q;
      endcase
    end
  end

  always_comb begin
    plen_c   = (32'(payload_length_i) > MAX_PAYLOAD) ? 16'(MAX_PAYLOAD)
                                                     : 16'(payload_length_i);
    wire_len = 16'(plen_c + 16'(WIRE_EXTRA));
    base_sum = first_byte_i ? 16'({8'h00, wire_len[15:8]} + {8'h00, wire_len[7:0]}
                                  + {8'h00, packet_type_i})
                            : sum_q;
    sum_d    = 16'(base_sum + {8'h00, data_byte_i});
    // stray bytes outside a packet are dropped
    job_en_o = first_byte_i || in_pkt_q;
    in_pkt_d = job_en_o && !final_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      in_pkt_q <= 1'b0;
    end else if (accept_i && job_en_o) begin
      sum_q    <= sum_d;
      in_pkt_q <= in_pkt_d;
    end
  end

  always_comb begin
    job_o.hdr       = first_byte_i;
    job_o.fin       = final_byte_i;
    job_o.wake_code = wake_code_q;
    job_o.dev_addr  = dev_addr_q;
    job_o.ptype     = packet_type_i;
    job_o.wire_len  = wire_len;
    job_o.data      = data_byte_i;
    job_o.sum       = sum_d;
  end

endmodule

FILE: sv/scpf_seq.sv
// ----------------------------------------------------------------------------
// scpf_seq
// Burst register and byte sequencer feeding the output register.
// ----------------------------------------------------------------------------
module scpf_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           job_en_i,
  input  scpf_pkg::job_t job_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     tx_byte_o,
  output logic           end_of_packet_o
);
  import scpf_pkg::*;

  job_t        job_q;
  logic        job_vld_q, job_vld_d;
  pos_e        pos_q, pos_d;
  logic        out_vld_q, out_vld_d;
  logic [7:0]  tx_q, tx_d;
  logic        eop_q, eop_d;
  logic        load;
  logic        at_last;

  assign load    = job_vld_q && (!out_vld_q || out_ready_i);
  assign at_last = job_q.fin ? (pos_q == POS_SUM_LO) : (pos_q == POS_DATA);
  assign ready_o = !job_vld_q || (load && at_last);

  // byte select for current position
  always_comb begin
    case (pos_q)
      POS_START_HI: tx_d = job_q.wake_code[15:8];
      POS_START_LO: tx_d = job_q.wake_code[7:0];
      POS_ADDR_3:   tx_d = job_q.dev_addr[31:24];
      POS_ADDR_2:   tx_d = job_q.dev_addr[23:16];
      POS_ADDR_1:   tx_d = job_q.dev_addr[15:8];
      POS_ADDR_0:   tx_d = job_q.dev_addr[7:0];
      POS_TYPE:     tx_d = job_q.ptype;
      POS_LEN_HI:   tx_d = job_q.wire_len[15:8];
      POS_LEN_LO:   tx_d = job_q.wire_len[7:0];
      POS_DATA:     tx_d = job_q.data;
      POS_SUM_HI:   tx_d = job_q.sum[15:8];
      POS_SUM_LO:   tx_d = job_q.sum[7:0];
      default:      tx_d = job_q.data;
    endcase
    eop_d = (pos_q == POS_SUM_LO);
  end

  always_comb begin
    job_vld_d = job_vld_q;
    pos_d     = pos_q;
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_vld_d = 1'b1;
      pos_d     = pos_e'(4'(pos_q) + 4'd1);
      if (at_last) begin
        job_vld_d = 1'b0;
      end
    end
    if (accept_i && job_en_i) begin
      job_vld_d = 1'b1;
      pos_d     = job_i.hdr ? POS_START_HI : POS_DATA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= POS_DATA;
    end else begin
      job_vld_q <= job_vld_d;
      out_vld_q <= out_vld_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && job_en_i) begin
      job_q <= job_i;
    end
    if (load) begin
      tx_q  <= tx_d;
      eop_q <= eop_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign tx_byte_o       = tx_q;
  assign end_of_packet_o = eop_q;

`ifndef SYNTH
  a_eop_on_sum_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && pos_q == POS_SUM_LO) |=> (out_vld_q && eop_q))
    else $error("low checksum byte not flagged as end of packet");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_vld_q |-> (pos_q != 4'd12 && pos_q != 4'd13 && pos_q != 4'd14
                   && pos_q != 4'd15))
    else $error("sequencer position out of range");

  a_no_sum_without_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_vld_q && !job_q.fin) |-> (pos_q != POS_SUM_HI && pos_q != POS_SUM_LO))
    else $error("checksum emitted for a non-final byte");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_vld_q |-> ready_o)
    else $error("input stalled with no burst pending");
`endif

endmodule

FILE: sv/sensor_command_packet_framer.sv
// ----------------------------------------------------------------------------
// sensor_command_packet_framer
// Length-prefixed command packet framer with 16-bit additive checksum.
// ----------------------------------------------------------------------------
// Path: a request is captured in the burst register, and its first byte moves
//   into the output register once that register is free.
// Throughput: one request per cycle for middle payload bytes while the output
//   is not stalled; a first byte expands to 10 output bytes, a final byte to 3,
//   a single-byte packet to 12, sent by the one-byte-per-cycle output register.
// Reset (async, active low) clears packet state, checksum and all valids;
//   config registers return to start code 0xEF01 and address 0xFFFFFFFF.
// ----------------------------------------------------------------------------
module sensor_command_packet_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // input request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  packet_type_i,
  input  logic [6:0]  payload_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        final_byte_i,
  // output byte channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        end_of_packet_o
);
  import scpf_pkg::*;

  logic accept;
  job_t job;
  logic job_en;

  // a request is taken whenever the burst register is free or its last byte is moving out
  assign accept = in_valid_i && in_ready_o;

  // front end: config, running checksum, open-packet flag
  scpf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accept_i         (accept),
    .packet_type_i    (packet_type_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .final_byte_i     (final_byte_i),
    .job_o            (job),
    .job_en_o         (job_en)
  );

  // back end: walks header / data / checksum bytes into the output register
  scpf_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .job_en_i        (job_en),
    .job_i           (job),
    .ready_o         (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_byte_o       (tx_byte_o),
    .end_of_packet_o (end_of_packet_o)
  );

endmodule
